[sv/pet_pkg.sv]
// Package for the pixel extrema tracker: shared types and fixed constants.
// No dependencies; compiled before every other file of the block.
`default_nettype none
package pet_pkg;

    // Fixed field widths of the frame tag and the component selector.
    localparam int TAG_BITS   = 8;
    localparam int COMPONENTS = 4;
    localparam int SEL_BITS   = 2;

    // Component selector codes.
    typedef enum logic [SEL_BITS-1:0] {
        SEL_COMP0 = 2'd0,
        SEL_COMP1 = 2'd1,
        SEL_COMP2 = 2'd2,
        SEL_COMP3 = 2'd3
    } t_sel;

    // Side information that travels with the selected sample.
    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic                last;
    } t_meta;

endpackage
`default_nettype wire

[sv/pet_if.sv]
// Valid/ready channel interfaces for pixels in and frame statistics out.
// Depends on pet_pkg for the tag width.
`default_nettype none
interface pet_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                              valid;
    logic                              ready;
    logic signed [SAMPLE_BITS-1:0]     sample_0;
    logic signed [SAMPLE_BITS-1:0]     sample_1;
    logic signed [SAMPLE_BITS-1:0]     sample_2;
    logic signed [SAMPLE_BITS-1:0]     sample_3;
    logic [pet_pkg::TAG_BITS-1:0]      frame_tag;
    logic                              last;

    modport source (output valid, sample_0, sample_1, sample_2, sample_3,
                    frame_tag, last, input ready);
    modport sink   (input valid, sample_0, sample_1, sample_2, sample_3,
                    frame_tag, last, output ready);
endinterface

interface pet_out_if #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 24
);
    logic                              valid;
    logic                              ready;
    logic [pet_pkg::TAG_BITS-1:0]      result_tag;
    logic signed [SAMPLE_BITS-1:0]     minimum_value;
    logic signed [SAMPLE_BITS-1:0]     second_minimum;
    logic signed [SAMPLE_BITS-1:0]     maximum_value;
    logic signed [SAMPLE_BITS-1:0]     second_maximum;
    logic [COUNT_BITS-1:0]             min_count;
    logic [COUNT_BITS-1:0]             max_count;

    modport source (output valid, result_tag, minimum_value, second_minimum,
                    maximum_value, second_maximum, min_count, max_count,
                    input ready);
    modport sink   (input valid, result_tag, minimum_value, second_minimum,
                    maximum_value, second_maximum, min_count, max_count,
                    output ready);
endinterface
`default_nettype wire

[sv/pet_select.sv]
// Input stage: selector register, component mux and the input pipeline register.
// Depends on pet_pkg and pet_in_if.
`default_nettype none
module pet_select #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [pet_pkg::SEL_BITS-1:0]      i_cfg_wdata,
    pet_in_if.sink                           i_pix,
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic signed [SAMPLE_BITS-1:0]    o_value,
    output pet_pkg::t_meta                   o_meta
);

    pet_pkg::t_sel                 r_sel;
    logic                          r_valid;
    logic signed [SAMPLE_BITS-1:0] r_value;
    pet_pkg::t_meta                r_meta;
    logic signed [SAMPLE_BITS-1:0] n_value;
    logic                          take;

    // Stage is free when empty or when its item leaves this cycle.
    assign i_pix.ready = !r_valid || i_ready;
    assign take        = i_pix.valid && i_pix.ready;

    always_comb begin
        case (r_sel)
            pet_pkg::SEL_COMP0: n_value = i_pix.sample_0;
            pet_pkg::SEL_COMP1: n_value = i_pix.sample_1;
            pet_pkg::SEL_COMP2: n_value = i_pix.sample_2;
            pet_pkg::SEL_COMP3: n_value = i_pix.sample_3;
            default:            n_value = i_pix.sample_0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel   <= pet_pkg::SEL_COMP0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_sel <= pet_pkg::t_sel'(i_cfg_wdata);
            end
            if (i_pix.ready) begin
                r_valid <= i_pix.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_value     <= n_value;
            r_meta.tag  <= i_pix.frame_tag;
            r_meta.last <= i_pix.last;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_meta  = r_meta;

endmodule
`default_nettype wire

[sv/pet_track.sv]
// Tracking stage: running extrema and tallies, plus the result register.
// Depends on pet_pkg and pet_out_if.
`default_nettype none
module pet_track #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 24
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire signed [SAMPLE_BITS-1:0]     i_value,
    input  wire pet_pkg::t_meta              i_meta,
    pet_out_if.source                        o_res
);

    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [COUNT_BITS-1:0]         CMAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0]         CONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

    logic                          r_frame_start;
    logic signed [SAMPLE_BITS-1:0] r_low_best, r_low_second, r_high_best, r_high_second;
    logic [COUNT_BITS-1:0]         r_low_tally, r_high_tally;

    logic signed [SAMPLE_BITS-1:0] b_low_best, b_low_second, b_high_best, b_high_second;
    logic [COUNT_BITS-1:0]         b_low_tally, b_high_tally;
    logic signed [SAMPLE_BITS-1:0] n_low_best, n_low_second, n_high_best, n_high_second;
    logic [COUNT_BITS-1:0]         n_low_tally, n_high_tally;
    logic signed [SAMPLE_BITS-1:0] n_sec_min, n_sec_max;

    logic                          r_out_valid;
    logic [pet_pkg::TAG_BITS-1:0]  r_tag;
    logic signed [SAMPLE_BITS-1:0] r_min, r_smin, r_max, r_smax;
    logic [COUNT_BITS-1:0]         r_min_cnt, r_max_cnt;
    logic                          take;

    assign o_ready = !r_out_valid || o_res.ready;
    assign take    = i_valid && o_ready;

    always_comb begin
        // First pixel of a frame starts from the sentinels.
        if (r_frame_start) begin
            b_low_best    = SMAX;
            b_low_second  = SMAX;
            b_high_best   = SMIN;
            b_high_second = SMIN;
            b_low_tally   = '0;
            b_high_tally  = '0;
        end else begin
            b_low_best    = r_low_best;
            b_low_second  = r_low_second;
            b_high_best   = r_high_best;
            b_high_second = r_high_second;
            b_low_tally   = r_low_tally;
            b_high_tally  = r_high_tally;
        end

        n_low_best   = b_low_best;
        n_low_second = b_low_second;
        n_low_tally  = b_low_tally;
        if (i_value < b_low_best) begin
            n_low_second = b_low_best;
            n_low_best   = i_value;
            n_low_tally  = CONE;
        end else if (i_value == b_low_best) begin
            n_low_tally = (b_low_tally == CMAX) ? CMAX : b_low_tally + CONE;
        end else if (i_value < b_low_second) begin
            n_low_second = i_value;
        end

        n_high_best   = b_high_best;
        n_high_second = b_high_second;
        n_high_tally  = b_high_tally;
        if (i_value > b_high_best) begin
            n_high_second = b_high_best;
            n_high_best   = i_value;
            n_high_tally  = CONE;
        end else if (i_value == b_high_best) begin
            n_high_tally = (b_high_tally == CMAX) ? CMAX : b_high_tally + CONE;
        end else if (i_value > b_high_second) begin
            n_high_second = i_value;
        end

        // Constant frame: both seconds report the single value.
        if (n_high_best == n_low_best) begin
            n_sec_min = n_high_best;
            n_sec_max = n_high_best;
        end else begin
            n_sec_min = n_low_second;
            n_sec_max = n_high_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_start <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            if (take) begin
                r_frame_start <= i_meta.last;
            end
            if (take && i_meta.last) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_low_best    <= n_low_best;
            r_low_second  <= n_low_second;
            r_high_best   <= n_high_best;
            r_high_second <= n_high_second;
            r_low_tally   <= n_low_tally;
            r_high_tally  <= n_high_tally;
        end
        if (take && i_meta.last) begin
            r_tag     <= i_meta.tag;
            r_min     <= n_low_best;
            r_smin    <= n_sec_min;
            r_max     <= n_high_best;
            r_smax    <= n_sec_max;
            r_min_cnt <= n_low_tally;
            r_max_cnt <= n_high_tally;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.result_tag     = r_tag;
    assign o_res.minimum_value  = r_min;
    assign o_res.second_minimum = r_smin;
    assign o_res.maximum_value  = r_max;
    assign o_res.second_maximum = r_smax;
    assign o_res.min_count      = r_min_cnt;
    assign o_res.max_count      = r_max_cnt;

endmodule
`default_nettype wire

[sv/pixel_extrema_tracker.sv]
// Pixel extrema tracker, top level.
// Result path: a frame's last pixel is registered in pet_select, then in the result register of pet_track.
// Throughput: one pixel per cycle; the two register stages stall only on o_res backpressure.
// Reset: synchronous, active-low i_rst_n; clears valids, selects component 0, opens a new frame.
// Depends on pet_pkg, pet_in_if, pet_out_if, pet_select and pet_track.
`default_nettype none
module pixel_extrema_tracker #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 24
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [pet_pkg::SEL_BITS-1:0]  i_cfg_wdata,
    pet_in_if.sink                       i_pix,
    pet_out_if.source                    o_res
);

    // Between the stages: selected sample with its tag and frame-end flag.
    logic                          s1_valid;
    logic                          s1_ready;
    logic signed [SAMPLE_BITS-1:0] s1_value;
    pet_pkg::t_meta                s1_meta;

    // Stage 1: component select under the configured selector, registered.
    pet_select #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_select (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (i_pix),
        .o_valid     (s1_valid),
        .i_ready     (s1_ready),
        .o_value     (s1_value),
        .o_meta      (s1_meta)
    );

    // Stage 2: min/max compare-update against the running state; on the
    // frame's last pixel the finished statistics land in the result register,
    // which holds them while the next frame already streams in.
    pet_track #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_value (s1_value),
        .i_meta  (s1_meta),
        .o_res   (o_res)
    );

`ifndef ASSERT_OFF
    // A new result appears only after a last-pixel transfer into stage 2.
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(s1_valid && s1_ready && s1_meta.last))
        else $error("result without a frame-end transfer");

    // Every reported frame has at least one pixel at each extreme.
    a_counts_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.min_count != '0) && (o_res.max_count != '0))
        else $error("zero extreme count in result");

    // Ordering of the reported extrema.
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.minimum_value <= o_res.maximum_value)
                     && (o_res.minimum_value <= o_res.second_minimum)
                     && (o_res.second_maximum <= o_res.maximum_value))
        else $error("extrema out of order");
`endif

endmodule
`default_nettype wire

[sim/tb_pixel_extrema_tracker.sv]
`timescale 1ns / 1ps
// Self-checking testbench for pixel_extrema_tracker: frame min/max statistics.
// Needs pet_pkg, pet_in_if, pet_out_if and the tracker RTL compiled first.
module tb_pixel_extrema_tracker;

    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 24;
    localparam int CYCLE_LIMIT = 300000;  // watchdog bound on the whole run
    localparam int HOLD_CYCLES = 150;     // long receiver hold-off under pressure
    localparam int SETTLE      = 4;       // settling wait in drain_results after the queue empties
    localparam int MAX_PRINTS  = 60;

    typedef logic signed [SAMPLE_BITS-1:0]  sample_t;
    typedef logic [COUNT_BITS-1:0]          tally_t;
    typedef logic [pet_pkg::TAG_BITS-1:0]   tag_t;

    localparam sample_t POS_SENTINEL = 16'sh7FFF;
    localparam sample_t NEG_SENTINEL = 16'sh8000;

    // One pixel as offered on the input channel.
    typedef struct packed {
        sample_t c3;
        sample_t c2;
        sample_t c1;
        sample_t c0;
        tag_t    tag;
        logic    last;
    } pixel_t;

    // Statistics expected for one finished frame.
    typedef struct packed {
        tag_t    tag;
        sample_t lo;
        sample_t lo2;
        sample_t hi;
        sample_t hi2;
        tally_t  lo_n;
        tally_t  hi_n;
    } frame_stats_t;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          cfg_we;
    pet_pkg::t_sel cfg_wdata;

    pet_in_if  #(.SAMPLE_BITS(SAMPLE_BITS))                         pix_if ();
    pet_out_if #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) res_if ();

    pixel_extrema_tracker #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_pix       (pix_if),
        .o_res       (res_if)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the selector and the frame tracking
    // ------------------------------------------------------------------
    pet_pkg::t_sel select_cfg;
    bit            frame_open;     // set: next pixel starts a fresh frame
    sample_t       lo_best, lo_second, hi_best, hi_second;
    tally_t        lo_tally, hi_tally;

    frame_stats_t frame_stats_q [$];   // finished frames still owed by the block

    int unsigned err_count = 0;
    int unsigned cycle_count = 0;
    bit          idle_enable;          // random gaps on both channels
    int unsigned hold_req_count = 0;   // raised by a test to ask for a long hold-off
    int unsigned hold_done_count = 0;  // requests already taken up by the receiver
    int unsigned res_hold_left = 0;
    int unsigned res_gap_left = 0;

    function automatic tally_t tally_bump(input tally_t t);
        return (t == '1) ? t : t + 1'b1;
    endfunction

    // Update tracking with one accepted pixel; queue the stats on the frame end.
    task automatic track_pixel(input pixel_t px);
        sample_t      v;
        frame_stats_t s;
        case (select_cfg)
            pet_pkg::SEL_COMP1: v = px.c1;
            pet_pkg::SEL_COMP2: v = px.c2;
            pet_pkg::SEL_COMP3: v = px.c3;
            default:            v = px.c0;
        endcase
        if (frame_open) begin
            lo_best    = POS_SENTINEL;
            lo_second  = POS_SENTINEL;
            hi_best    = NEG_SENTINEL;
            hi_second  = NEG_SENTINEL;
            lo_tally   = '0;
            hi_tally   = '0;
            frame_open = 1'b0;
        end
        // low side: a new minimum pushes the old one down to second place
        if (v < lo_best) begin
            lo_second = lo_best;
            lo_best   = v;
            lo_tally  = tally_t'(1);
        end else if (v == lo_best) begin
            lo_tally = tally_bump(lo_tally);
        end else if (v < lo_second) begin
            lo_second = v;
        end
        // high side, mirrored
        if (v > hi_best) begin
            hi_second = hi_best;
            hi_best   = v;
            hi_tally  = tally_t'(1);
        end else if (v == hi_best) begin
            hi_tally = tally_bump(hi_tally);
        end else if (v > hi_second) begin
            hi_second = v;
        end
        if (px.last) begin
            s.tag  = px.tag;
            s.lo   = lo_best;
            s.hi   = hi_best;
            s.lo_n = lo_tally;
            s.hi_n = hi_tally;
            // constant frame: both seconds collapse onto the single value
            s.lo2  = (hi_best == lo_best) ? hi_best : lo_second;
            s.hi2  = (hi_best == lo_best) ? hi_best : hi_second;
            frame_stats_q.push_back(s);
            frame_open = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Error reporting
    // ------------------------------------------------------------------
    task automatic report_error(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want,
                               input int tag);
        if (got !== want)
            report_error($sformatf("frame %0d %s: got %0d, expected %0d",
                                   tag, name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Result side: ready driver with random gaps and the long hold-off
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req_count != hold_done_count) begin
            hold_done_count = hold_req_count;
            res_hold_left   = HOLD_CYCLES;
        end
        if (res_hold_left != 0) begin
            res_hold_left--;
            res_if.ready <= 1'b0;
        end else if (res_gap_left != 0) begin
            res_gap_left--;
            res_if.ready <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 6) == 0) begin
            res_gap_left = $urandom_range(1, 6) - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // Result checker: every transfer on o_res is matched against the oldest
    // pending frame. Values read here are the ones before this edge.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            frame_stats_t want;
            if (frame_stats_q.size() == 0) begin
                report_error($sformatf("result for frame %0d with no frame pending",
                                       res_if.result_tag));
            end else begin
                want = frame_stats_q.pop_front();
                check_field("result_tag", int'(res_if.result_tag), int'(want.tag),
                            int'(want.tag));
                check_field("minimum_value", int'(res_if.minimum_value),
                            int'(want.lo), int'(want.tag));
                check_field("second_minimum", int'(res_if.second_minimum),
                            int'(want.lo2), int'(want.tag));
                check_field("maximum_value", int'(res_if.maximum_value),
                            int'(want.hi), int'(want.tag));
                check_field("second_maximum", int'(res_if.second_maximum),
                            int'(want.hi2), int'(want.tag));
                check_field("min_count", int'(res_if.min_count), int'(want.lo_n),
                            int'(want.tag));
                check_field("max_count", int'(res_if.max_count), int'(want.hi_n),
                            int'(want.tag));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_pixel_extrema_tracker: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Pixel side
    // ------------------------------------------------------------------

    // Value patterns: full range, a narrow band (lots of ties), the four
    // values at the ends of the range, and a small band from 0 to 5.
    function automatic sample_t pick_value(input int mode);
        sample_t ends [4];
        ends[0] = NEG_SENTINEL;
        ends[1] = NEG_SENTINEL + sample_t'(1);
        ends[2] = POS_SENTINEL - sample_t'(1);
        ends[3] = POS_SENTINEL;
        case (mode)
            0:       return sample_t'($urandom);
            1:       return sample_t'(int'($urandom_range(0, 8)) - 4);
            2:       return ends[$urandom_range(0, 3)];
            default: return sample_t'($urandom_range(0, 5));
        endcase
    endfunction

    // Builds a pixel with v in the selected slot and noise in the others.
    function automatic pixel_t make_pixel(input sample_t v, input tag_t tag,
                                          input logic last);
        pixel_t px;
        px.c0   = sample_t'($urandom);
        px.c1   = sample_t'($urandom);
        px.c2   = sample_t'($urandom);
        px.c3   = sample_t'($urandom);
        px.tag  = tag;
        px.last = last;
        case (select_cfg)
            pet_pkg::SEL_COMP1: px.c1 = v;
            pet_pkg::SEL_COMP2: px.c2 = v;
            pet_pkg::SEL_COMP3: px.c3 = v;
            default:            px.c0 = v;
        endcase
        return px;
    endfunction

    // One pixel transfer. Valid stays high between back-to-back pixels;
    // callers drop it through drain_results once they stop sending.
    task automatic send_pixel(input pixel_t px);
        if (idle_enable && $urandom_range(0, 5) == 0) begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        pix_if.valid     <= 1'b1;
        pix_if.sample_0  <= px.c0;
        pix_if.sample_1  <= px.c1;
        pix_if.sample_2  <= px.c2;
        pix_if.sample_3  <= px.c3;
        pix_if.frame_tag <= px.tag;
        pix_if.last      <= px.last;
        do @(posedge i_clk); while (!pix_if.ready);
        track_pixel(px);
    endtask

    // A complete frame of n pixels drawn from one value pattern.
    task automatic send_frame(input int n, input int mode);
        tag_t tag;
        tag = tag_t'($urandom_range(0, 255));
        for (int i = 0; i < n; i++)
            send_pixel(make_pixel(pick_value(mode), tag, i == n - 1));
    endtask

    // Stop offering pixels and wait until every finished frame has come out.
    task automatic drain_results();
        pix_if.valid <= 1'b0;
        while (frame_stats_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Selector writes only happen with the block idle.
    task automatic write_select(input pet_pkg::t_sel s);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= s;
        @(posedge i_clk);
        cfg_we     <= 1'b0;
        select_cfg = s;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked frames: range ends, constant frames, ties on both extremes,
    // second extremes arriving before and after the extreme itself.
    task automatic test_directed();
        sample_t vals [22];
        int      lens [7];
        tag_t    tags [7];
        int      k;
        vals = '{16'sh7FFF,
                 16'sh8000,
                 16'sh8000, 16'sh7FFF,
                 7, 7, 7,
                 3, 1, 4, 1, 5, 9, 2, 6, 9,
                 10, 20, 20, 15,
                 -1, 0};
        lens = '{1, 1, 2, 3, 9, 4, 2};
        tags = '{8'd0, 8'd255, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5};
        k = 0;
        for (int f = 0; f < 7; f++) begin
            for (int i = 0; i < lens[f]; i++) begin
                send_pixel(make_pixel(vals[k], tags[f], i == lens[f] - 1));
                k++;
            end
        end
        drain_results();
    endtask

    // Every selector value, the ends 0 and 3 among them.
    task automatic test_components();
        for (int s = 0; s < pet_pkg::COMPONENTS; s++) begin
            write_select(pet_pkg::t_sel'(s));
            repeat (3) send_frame($urandom_range(1, 5), $urandom_range(0, 3));
        end
        drain_results();
    endtask

    // Bulk random frames in batches, selector rewritten between batches.
    // Mostly short frames, some medium, a few long ones.
    task automatic test_random_frames(input int batches, input int per_batch);
        int sent;
        int len;
        int pick;
        for (int b = 0; b < batches; b++) begin
            idle_enable = ($urandom_range(0, 3) != 0);
            write_select(pet_pkg::t_sel'($urandom_range(0, 3)));
            sent = 0;
            while (sent < per_batch) begin
                pick = $urandom_range(0, 19);
                if (pick < 16)      len = $urandom_range(1, 12);
                else if (pick < 19) len = $urandom_range(13, 60);
                else                len = $urandom_range(100, 250);
                send_frame(len, $urandom_range(0, 3));
                sent += len;
            end
        end
        idle_enable = 1'b1;
        drain_results();
    endtask

    // Receiver holds off for a long stretch while single-pixel frames keep
    // coming: the output stages fill and the block must stall its input.
    task automatic test_backpressure();
        hold_req_count++;
        repeat (40) send_frame(1, $urandom_range(0, 3));
        drain_results();
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_full_rate();
        idle_enable = 1'b0;
        write_select(pet_pkg::SEL_COMP3);
        repeat (30) send_frame($urandom_range(1, 8), $urandom_range(0, 3));
        write_select(pet_pkg::SEL_COMP0);
        repeat (10) send_frame($urandom_range(1, 8), $urandom_range(0, 3));
        drain_results();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = pet_pkg::SEL_COMP0;
        pix_if.valid     = 1'b0;
        pix_if.sample_0  = '0;
        pix_if.sample_1  = '0;
        pix_if.sample_2  = '0;
        pix_if.sample_3  = '0;
        pix_if.frame_tag = '0;
        pix_if.last      = 1'b0;
        idle_enable      = 1'b1;
        select_cfg       = pet_pkg::SEL_COMP0;
        frame_open       = 1'b1;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Counter saturation needs 2^24 pixels in one frame; far beyond
        // a run of this length, so it is not exercised here.
        test_directed();
        test_components();
        test_random_frames(10, 100);
        test_backpressure();
        test_full_rate();

        if (err_count == 0)
            $display("tb_pixel_extrema_tracker: done, clean");
        else
            $display("tb_pixel_extrema_tracker: done, errors");
        $finish;
    end

endmodule
